// File: design/cfc_pkg.sv
// Shared types, constants and the CRC-16/ARC byte update for the command
// frame checker. No dependencies; every other design file imports this one.
`default_nettype none

package cfc_pkg;

  // Longest frame accepted; longer frames are rejected.
  localparam int unsigned MAX_FRAME_BYTES = 4096;
  // Position counter saturates at MAX_FRAME_BYTES, so it must hold that value.
  localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);

  typedef logic [POS_W-1:0] pos_t;

  // Frame field values
  localparam logic [7:0]  CODEC_ID   = 8'h0C;
  localparam logic [7:0]  QTY_ONE    = 8'h01;
  localparam logic [7:0]  CMD_TYPE   = 8'h05;
  localparam logic [7:0]  ALIAS_HEAD = 8'hAC;
  localparam logic [7:0]  ALIAS_C0   = 8'hC0;
  localparam logic [7:0]  ALIAS_C1   = 8'hC1;
  localparam logic [7:0]  CHAR_LO    = 8'd32;
  localparam logic [7:0]  CHAR_HI    = 8'd126;
  localparam logic [7:0]  CHAR_SPACE = 8'd32;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  // Result kinds
  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_REJECT = 2'd0,
    VERDICT_TEXT   = 2'd1,
    VERDICT_ACC0   = 2'd2,
    VERDICT_ACC1   = 2'd3
  } verdict_t;

  // One received byte
  typedef struct packed {
    logic [7:0] in_byte;
    logic       frame_end;
  } in_item_t;

  // One result
  typedef struct packed {
    logic       kind;
    logic [7:0] cmd_byte;
    verdict_t   verdict;
  } out_item_t;

  // Result of processing one byte: whether a result is produced, and what
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } step_res_t;

  // CRC-16/ARC update by one byte, reflected, eight shift steps unrolled
  function automatic logic [15:0] crc_arc_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: design/cfc_in_reg.sv
// Input register of the command frame checker: holds one accepted request
// until the frame logic takes it. Depends on cfc_pkg.
`default_nettype none

module cfc_in_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire cfc_pkg::in_item_t in_data,
  input  wire logic              advance,
  output logic                   in_stall,
  output logic                   held_valid,
  output cfc_pkg::in_item_t      held_data
);
  import cfc_pkg::*;

  // Stall only while a held request cannot move on
  assign in_stall = held_valid && !advance;

  // Hold register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      held_data <= in_data;
    end
  end

endmodule

`default_nettype wire

// File: design/cfc_frame.sv
// Frame state and per-byte checks of the command frame checker: field
// parsing, CRC-16/ARC, command echo and the final verdict. Depends on cfc_pkg.
`default_nettype none

module cfc_frame (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire cfc_pkg::in_item_t item,
  output cfc_pkg::step_res_t     res
);
  import cfc_pkg::*;

  localparam pos_t POS_LEN     = pos_t'(4);
  localparam pos_t POS_CODEC   = pos_t'(8);
  localparam pos_t POS_QTY     = pos_t'(9);
  localparam pos_t POS_TYPE    = pos_t'(10);
  localparam pos_t POS_CLEN    = pos_t'(11);
  localparam pos_t POS_CLEN_LS = pos_t'(14);
  localparam pos_t POS_CMD     = pos_t'(15);
  localparam pos_t POS_MAX     = pos_t'(MAX_FRAME_BYTES);

  // Frame state registers
  pos_t        byte_position;
  logic [31:0] data_length;
  logic [31:0] command_length;
  logic [15:0] crc_accumulator;
  logic [31:0] received_crc;
  logic        frame_failed;
  logic        all_printable;
  logic        seen_nonspace;
  logic [7:0]  first_cmd_byte;
  logic [7:0]  second_cmd_byte;

  pos_t        byte_position_next;
  logic [31:0] data_length_next;
  logic [31:0] command_length_next;
  logic [15:0] crc_accumulator_next;
  logic [31:0] received_crc_next;
  logic        frame_failed_next;
  logic        all_printable_next;
  logic        seen_nonspace_next;
  logic [7:0]  first_cmd_byte_next;
  logic [7:0]  second_cmd_byte_next;

  logic [31:0] pos32;
  logic [31:0] off_data;
  logic [31:0] off_cmd;
  logic [7:0]  b;
  logic        echo;
  logic        len_ok;
  verdict_t    verdict;

  assign b        = item.in_byte;
  assign pos32    = 32'(byte_position);
  assign off_data = pos32 - 32'd8;
  assign off_cmd  = pos32 - 32'd15;

  // Per-byte field checks and state update
  always_comb begin
    byte_position_next   = byte_position;
    data_length_next     = data_length;
    command_length_next  = command_length;
    crc_accumulator_next = crc_accumulator;
    received_crc_next    = received_crc;
    frame_failed_next    = frame_failed;
    all_printable_next   = all_printable;
    seen_nonspace_next   = seen_nonspace;
    first_cmd_byte_next  = first_cmd_byte;
    second_cmd_byte_next = second_cmd_byte;
    echo                 = 1'b0;

    if (byte_position >= POS_MAX) begin
      // too long: counter stays saturated
      frame_failed_next = 1'b1;
    end else begin
      if (byte_position < POS_LEN) begin
        if (b != 8'h00) frame_failed_next = 1'b1;
      end else if (byte_position < POS_CODEC) begin
        data_length_next = {data_length[23:0], b};
      end else if (off_data < data_length) begin
        crc_accumulator_next = crc_arc_byte(crc_accumulator, b);
      end else begin
        received_crc_next = {received_crc[23:0], b};
      end

      if (byte_position == POS_CODEC && b != CODEC_ID) frame_failed_next = 1'b1;
      if (byte_position == POS_QTY && b != QTY_ONE) frame_failed_next = 1'b1;
      if (byte_position == POS_TYPE && b != CMD_TYPE) frame_failed_next = 1'b1;

      if (byte_position >= POS_CLEN && byte_position <= POS_CLEN_LS) begin
        command_length_next = {command_length[23:0], b};
      end

      // command length must be nonzero and match data length less eight
      if (byte_position == POS_CLEN_LS) begin
        if (command_length_next == 32'd0 || data_length < 32'd8 ||
            command_length_next != data_length - 32'd8) begin
          frame_failed_next = 1'b1;
        end
      end

      if (byte_position >= POS_CMD) begin
        if (off_cmd < command_length) begin
          if (off_cmd == 32'd0) first_cmd_byte_next = b;
          if (off_cmd == 32'd1) second_cmd_byte_next = b;
          if (b < CHAR_LO || b > CHAR_HI) all_printable_next = 1'b0;
          if (b != CHAR_SPACE) seen_nonspace_next = 1'b1;
          echo = 1'b1;
        end else if (off_cmd == command_length) begin
          if (b != QTY_ONE) frame_failed_next = 1'b1;
        end
      end

      byte_position_next = byte_position + pos_t'(1);
    end
  end

  // Verdict from the state as it stands after this byte
  assign len_ok = ({1'b0, pos32} + 33'd1) == ({1'b0, data_length_next} + 33'd12);

  always_comb begin
    verdict = VERDICT_REJECT;
    if (!frame_failed_next && len_ok &&
        received_crc_next == {16'h0000, crc_accumulator_next}) begin
      if (command_length_next == 32'd2 && first_cmd_byte_next == ALIAS_HEAD &&
          (second_cmd_byte_next == ALIAS_C0 || second_cmd_byte_next == ALIAS_C1)) begin
        verdict = (second_cmd_byte_next == ALIAS_C1) ? VERDICT_ACC1 : VERDICT_ACC0;
      end else if (all_printable_next && seen_nonspace_next) begin
        verdict = VERDICT_TEXT;
      end
    end
  end

  // Result: verdict on the last byte, otherwise echo of a command byte
  always_comb begin
    res = '0;
    if (item.frame_end) begin
      res.valid        = 1'b1;
      res.item.kind    = KIND_VERDICT;
      res.item.verdict = verdict;
    end else if (echo) begin
      res.valid         = 1'b1;
      res.item.kind     = KIND_BYTE;
      res.item.cmd_byte = b;
      res.item.verdict  = VERDICT_REJECT;
    end
  end

  // State registers; everything returns to reset after a verdict
  always_ff @(posedge clk) begin
    if (rst || (step && item.frame_end)) begin
      byte_position   <= '0;
      data_length     <= '0;
      command_length  <= '0;
      crc_accumulator <= '0;
      received_crc    <= '0;
      frame_failed    <= 1'b0;
      all_printable   <= 1'b1;
      seen_nonspace   <= 1'b0;
      first_cmd_byte  <= '0;
      second_cmd_byte <= '0;
    end else if (step) begin
      byte_position   <= byte_position_next;
      data_length     <= data_length_next;
      command_length  <= command_length_next;
      crc_accumulator <= crc_accumulator_next;
      received_crc    <= received_crc_next;
      frame_failed    <= frame_failed_next;
      all_printable   <= all_printable_next;
      seen_nonspace   <= seen_nonspace_next;
      first_cmd_byte  <= first_cmd_byte_next;
      second_cmd_byte <= second_cmd_byte_next;
    end
  end

endmodule

`default_nettype wire

// File: design/cfc_out_reg.sv
// Result register of the command frame checker: holds one result request
// until the receiver takes it. Depends on cfc_pkg.
`default_nettype none

module cfc_out_reg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire cfc_pkg::out_item_t load_data,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output cfc_pkg::out_item_t      out_data
);
  import cfc_pkg::*;

  // Valid flag: set on load, cleared once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

endmodule

`default_nettype wire

// File: design/command_frame_checker.sv
// Top level of the command frame checker: input register, frame logic and
// result register. Depends on cfc_pkg, cfc_in_reg, cfc_frame, cfc_out_reg.
//
//   channel  direction  handshake                    payload
//   frame    in         frame_valid / frame_stall    frame_data  (in_item_t)
//   result   out        result_valid / result_stall  result_data (out_item_t)
//
// One byte is accepted per cycle while frame_stall is low. A byte's result
// (echo or verdict), where it has one, passes from the input register through
// the frame logic into the result register and shows on result_valid from there.
// Reset (rst, synchronous) empties both registers and clears the frame state.
// frame_stall rises only when the input register is full and the result
// register holds a result that is itself stalled.
`default_nettype none

module command_frame_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               frame_valid,
  output logic                    frame_stall,
  input  wire cfc_pkg::in_item_t  frame_data,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output cfc_pkg::out_item_t      result_data
);
  import cfc_pkg::*;

  logic      held_valid;
  in_item_t  held_data;
  logic      advance;
  step_res_t res;

  // Held byte moves on when the result register is free or being emptied
  assign advance = held_valid && (!result_valid || !result_stall);

  cfc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (frame_valid),
    .in_data    (frame_data),
    .advance    (advance),
    .in_stall   (frame_stall),
    .held_valid (held_valid),
    .held_data  (held_data)
  );

  cfc_frame u_frame (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (held_data),
    .res  (res)
  );

  cfc_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && res.valid),
    .load_data (res.item),
    .out_stall (result_stall),
    .out_valid (result_valid),
    .out_data  (result_data)
  );

endmodule

`default_nettype wire

// File: design/cfc_checker.sv
// Port-level checks for the command frame checker, and the bind that attaches
// them to the top level. Depends on cfc_pkg and command_frame_checker.
`default_nettype none

module cfc_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               frame_valid,
  input  wire logic               frame_stall,
  input  wire cfc_pkg::in_item_t  frame_data,
  input  wire logic               result_valid,
  input  wire logic               result_stall,
  input  wire cfc_pkg::out_item_t result_data
);
  import cfc_pkg::*;

  // An echoed byte never carries a verdict
  a_echo_no_verdict: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_data.kind == KIND_BYTE) |->
      result_data.verdict == VERDICT_REJECT)
    else $error("echo request carries a verdict");

  // A verdict carries no command byte
  a_verdict_no_byte: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_data.kind == KIND_VERDICT) |->
      result_data.cmd_byte == 8'h00)
    else $error("verdict request carries a command byte");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result pending after reset");

  // A stalled result is held unchanged
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result_data)))
    else $error("stalled result request changed");

  // A stalled frame byte is held unchanged
  a_frame_hold: assert property (@(posedge clk) disable iff (rst)
    (frame_valid && frame_stall) |=> (frame_valid && $stable(frame_data)))
    else $error("stalled frame request changed");

endmodule

bind command_frame_checker cfc_checker u_cfc_checker (
  .clk          (clk),
  .rst          (rst),
  .frame_valid  (frame_valid),
  .frame_stall  (frame_stall),
  .frame_data   (frame_data),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_data  (result_data)
);

`default_nettype wire

// File: bench/command_frame_checker_tb.sv
// Testbench for command_frame_checker: directed and random command frames,
// checked result by result against a predictor held in this file.
// Depends on cfc_pkg and the command_frame_checker design.

module command_frame_checker_tb;
  import cfc_pkg::*;

  logic      clk          = 1'b0;
  logic      rst          = 1'b1;
  logic      frame_valid  = 1'b0;
  logic      frame_stall;
  in_item_t  frame_data   = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  out_item_t result_data;

  command_frame_checker dut (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .frame_data   (frame_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idling controls, percent of cycles
  int gap_pct   = 0;
  int stall_pct = 0;

  int error_count   = 0;
  int bytes_sent    = 0;
  int frames_sent   = 0;
  int echo_count    = 0;
  int verdict_tally[4] = '{0, 0, 0, 0};

  // Frame under construction and its command bytes
  logic [7:0] frame_q[$];
  logic [7:0] cmd_q[$];

  // Echoes and verdicts still to come out of the block, oldest first
  out_item_t echoes_and_verdicts[$];

  // Tracked frame state
  logic [31:0] fs_pos;
  logic [31:0] fs_dlen;
  logic [31:0] fs_clen;
  logic [31:0] fs_rcrc;
  logic [15:0] fs_crc;
  logic        fs_failed;
  logic        fs_printable;
  logic        fs_nonspace;
  logic [7:0]  fs_cmd0;
  logic [7:0]  fs_cmd1;

  // CRC-16/ARC, fed one bit at a time, LSB first
  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] x;
    x = c;
    for (int i = 0; i < 8; i++) begin
      x = (x[0] ^ d[i]) ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

  // Append one byte to the frame or to the command
  task automatic append_frame(input logic [7:0] b);
    frame_q.insert(frame_q.size(), b);
  endtask

  task automatic append_cmd(input logic [7:0] b);
    cmd_q.insert(cmd_q.size(), b);
  endtask

  task automatic clear_frame_state();
    fs_pos       = '0;
    fs_dlen      = '0;
    fs_clen      = '0;
    fs_rcrc      = '0;
    fs_crc       = '0;
    fs_failed    = 1'b0;
    fs_printable = 1'b1;
    fs_nonspace  = 1'b0;
    fs_cmd0      = '0;
    fs_cmd1      = '0;
  endtask

  // Advance the frame state by one accepted byte and queue what it yields
  task automatic advance_frame_state(input logic [7:0] b, input logic last);
    logic [31:0] p;
    logic [31:0] ci;
    out_item_t   r;
    verdict_t    v;
    p = fs_pos;
    if (p >= MAX_FRAME_BYTES) begin
      fs_failed = 1'b1;
    end else begin
      if (p < 32'd4) begin
        if (b != 8'h00) fs_failed = 1'b1;
      end else if (p < 32'd8) begin
        fs_dlen = {fs_dlen[23:0], b};
      end else if (p - 32'd8 < fs_dlen) begin
        fs_crc = crc_step(fs_crc, b);
      end else begin
        fs_rcrc = {fs_rcrc[23:0], b};
      end
      if (p == 32'd8 && b != CODEC_ID) fs_failed = 1'b1;
      if (p == 32'd9 && b != QTY_ONE) fs_failed = 1'b1;
      if (p == 32'd10 && b != CMD_TYPE) fs_failed = 1'b1;
      if (p >= 32'd11 && p <= 32'd14) fs_clen = {fs_clen[23:0], b};
      if (p == 32'd14 && (fs_clen == 0 || fs_dlen < 32'd8 || fs_clen != fs_dlen - 32'd8)) begin
        fs_failed = 1'b1;
      end
      // Command bytes are echoed whatever the frame's health, unless the byte ends the frame
      if (p >= 32'd15) begin
        ci = p - 32'd15;
        if (ci < fs_clen) begin
          if (ci == 0) fs_cmd0 = b;
          if (ci == 1) fs_cmd1 = b;
          if (b < CHAR_LO || b > CHAR_HI) fs_printable = 1'b0;
          if (b != CHAR_SPACE) fs_nonspace = 1'b1;
          if (!last) begin
            r.kind     = KIND_BYTE;
            r.cmd_byte = b;
            r.verdict  = VERDICT_REJECT;
            echoes_and_verdicts.insert(echoes_and_verdicts.size(), r);
            echo_count++;
          end
        end else if (ci == fs_clen) begin
          if (b != QTY_ONE) fs_failed = 1'b1;
        end
      end
      fs_pos = p + 32'd1;
    end

    // Verdict on the last byte, then back to the reset state
    if (last) begin
      v = VERDICT_REJECT;
      if (!fs_failed && ({1'b0, p} + 33'd1 == {1'b0, fs_dlen} + 33'd12) &&
          fs_rcrc == {16'h0000, fs_crc}) begin
        if (fs_clen == 32'd2 && fs_cmd0 == ALIAS_HEAD &&
            (fs_cmd1 == ALIAS_C0 || fs_cmd1 == ALIAS_C1)) begin
          v = (fs_cmd1 == ALIAS_C1) ? VERDICT_ACC1 : VERDICT_ACC0;
        end else if (fs_printable && fs_nonspace) begin
          v = VERDICT_TEXT;
        end
      end
      r.kind     = KIND_VERDICT;
      r.cmd_byte = 8'h00;
      r.verdict  = v;
      echoes_and_verdicts.insert(echoes_and_verdicts.size(), r);
      verdict_tally[v]++;
      clear_frame_state();
    end
  endtask

  task automatic set_idling(input int send_gap, input int recv_stall);
    gap_pct   = send_gap;
    stall_pct = recv_stall;
  endtask

  // Receiver stalls at random
  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  // Drive one request on the frame channel and wait for it to be taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      frame_valid <= 1'b0;
      @(negedge clk);
    end
    frame_valid <= 1'b1;
    frame_data  <= '{in_byte: b, frame_end: last};
    @(posedge clk);
    while (frame_stall) @(posedge clk);
    bytes_sent++;
    advance_frame_state(b, last);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
    frames_sent++;
  endtask

  task automatic put_word(input int at, input logic [31:0] w);
    for (int k = 0; k < 4; k++) frame_q[at + k] = w[31 - 8*k -: 8];
  endtask

  // Well-formed frame around cmd_q, lengths and CRC filled in
  task automatic build_frame();
    logic [31:0] clen;
    logic [15:0] crc;
    clen = cmd_q.size();
    frame_q = {};
    repeat (8) append_frame(8'h00);
    append_frame(CODEC_ID);
    append_frame(QTY_ONE);
    append_frame(CMD_TYPE);
    repeat (4) append_frame(8'h00);
    foreach (cmd_q[i]) append_frame(cmd_q[i]);
    append_frame(QTY_ONE);
    put_word(4, clen + 32'd8);
    put_word(11, clen);
    crc = 16'h0000;
    for (int i = 8; i < frame_q.size(); i++) crc = crc_step(crc, frame_q[i]);
    repeat (2) append_frame(8'h00);
    append_frame(crc[15:8]);
    append_frame(crc[7:0]);
  endtask

  task automatic load_cmd(input string s);
    cmd_q = {};
    for (int i = 0; i < s.len(); i++) append_cmd(s[i]);
  endtask

  task automatic send_command();
    build_frame();
    send_frame();
  endtask

  // Printable text, edges of the printable range, bytes outside it
  task automatic test_text_commands();
    set_idling(0, 0);
    load_cmd("A");
    send_command();
    load_cmd(" ~");
    send_command();
    cmd_q = {8'h41, 8'h1F};
    send_command();
    cmd_q = {8'h7F};
    send_command();
    cmd_q = {8'h00, 8'hFF};
    send_command();
  endtask

  // The two binary aliases and near misses
  task automatic test_alias_commands();
    set_idling(30, 30);
    cmd_q = {ALIAS_HEAD, ALIAS_C0};
    send_command();
    cmd_q = {ALIAS_HEAD, ALIAS_C1};
    send_command();
    cmd_q = {ALIAS_HEAD, 8'hC2};
    send_command();
    cmd_q = {ALIAS_HEAD, ALIAS_C0, 8'h41};
    send_command();
    cmd_q = {ALIAS_C0, ALIAS_HEAD};
    send_command();
  endtask

  // An all-space command is rejected, one with a letter is not
  task automatic test_space_commands();
    set_idling(0, 30);
    load_cmd("   ");
    send_command();
    load_cmd("  a");
    send_command();
  endtask

  // Faults in the fixed fields and the two length words
  task automatic test_header_faults();
    set_idling(76, 0);
    load_cmd("OK");
    build_frame();
    frame_q[2] = 8'h80;
    send_frame();
    build_frame();
    frame_q[8] = 8'h0D;
    send_frame();
    build_frame();
    frame_q[9] = 8'h00;
    send_frame();
    build_frame();
    frame_q[10] = 8'h04;
    send_frame();
    build_frame();
    put_word(11, 32'd0);
    send_frame();
    build_frame();
    put_word(11, 32'd3);
    send_frame();
    build_frame();
    put_word(4, 32'd3);
    send_frame();
    build_frame();
    frame_q[frame_q.size() - 5] = 8'h02;
    send_frame();
  endtask

  // Wrong CRC, and a right lower half under a nonzero upper half
  task automatic test_crc_faults();
    set_idling(0, 76);
    load_cmd("getver");
    build_frame();
    frame_q[frame_q.size() - 1] ^= 8'h01;
    send_frame();
    build_frame();
    frame_q[frame_q.size() - 4] = 8'h01;
    send_frame();
  endtask

  // Frame ends early or late, a lone last byte, the largest length word
  task automatic test_length_faults();
    set_idling(30, 30);
    load_cmd("xyz");
    build_frame();
    void'(frame_q.pop_back());
    send_frame();
    build_frame();
    append_frame(8'h00);
    send_frame();
    frame_q = {8'hFF};
    send_frame();
    build_frame();
    put_word(4, 32'hFFFF_FFFF);
    while (frame_q.size() > 16) void'(frame_q.pop_back());
    send_frame();
  endtask

  // One random frame: mostly well-formed, some faulted, some noise
  task automatic random_frame();
    int len;
    int sel;
    int pos;
    len = ($urandom_range(9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
    sel = $urandom_range(99);
    cmd_q = {};
    if (sel < 45) begin
      repeat (len) append_cmd(8'($urandom_range(32, 126)));
    end else if (sel < 60) begin
      cmd_q = {ALIAS_HEAD, ($urandom_range(1) != 0) ? ALIAS_C1 : ALIAS_C0};
    end else if (sel < 68) begin
      repeat (len) append_cmd(CHAR_SPACE);
    end else if (sel < 84) begin
      repeat (len) append_cmd(8'($urandom_range(255)));
    end else begin
      repeat (len) append_cmd(8'($urandom_range(32, 126)));
      cmd_q[$urandom_range(len - 1)] = 8'($urandom_range(255));
    end
    build_frame();

    if ($urandom_range(99) >= 70) begin
      case ($urandom_range(10))
        0: frame_q[$urandom_range(3)] = 8'($urandom_range(1, 255));
        1: frame_q[8] ^= 8'($urandom_range(1, 255));
        2: frame_q[9] ^= 8'($urandom_range(1, 255));
        3: frame_q[10] ^= 8'($urandom_range(1, 255));
        4: put_word(11, ($urandom_range(1) != 0) ? 32'd0 : 32'($urandom_range(60)));
        5: put_word(4, $urandom);
        6: frame_q[frame_q.size() - 5] ^= 8'($urandom_range(1, 255));
        7: begin
          pos = frame_q.size() - 1 - $urandom_range(3);
          frame_q[pos] ^= 8'($urandom_range(1, 255));
        end
        8: repeat ($urandom_range(1, 20)) void'(frame_q.pop_back());
        9: repeat ($urandom_range(1, 5)) append_frame(8'($urandom_range(255)));
        default: begin
          frame_q = {};
          repeat ($urandom_range(1, 30)) append_frame(8'($urandom_range(255)));
        end
      endcase
    end
    send_frame();
  endtask

  task automatic test_random_frames(input int n_bytes);
    int start;
    start = bytes_sent;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_idling(0, 0);
        1: set_idling(76, 0);
        2: set_idling(0, 76);
        default: set_idling(30, 30);
      endcase
      while (bytes_sent - start < n_bytes * (ph + 1) / 4) random_frame();
    end
  endtask

  // Compare each result taken from the block with the oldest one due
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && result_valid && !result_stall) begin
      if (echoes_and_verdicts.size() == 0) begin
        error_count++;
        $error("unexpected result: kind %0d cmd_byte %02h verdict %0d",
               result_data.kind, result_data.cmd_byte, result_data.verdict);
      end else begin
        want = echoes_and_verdicts.pop_front();
        if (result_data.kind !== want.kind) begin
          error_count++;
          $error("kind: expected %0d, got %0d", want.kind, result_data.kind);
        end
        if (result_data.cmd_byte !== want.cmd_byte) begin
          error_count++;
          $error("cmd_byte: expected %02h, got %02h", want.cmd_byte, result_data.cmd_byte);
        end
        if (result_data.verdict !== want.verdict) begin
          error_count++;
          $error("verdict: expected %0d, got %0d", want.verdict, result_data.verdict);
        end
      end
    end
  end

  // Watchdog
  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    clear_frame_state();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_text_commands();
    test_alias_commands();
    test_space_commands();
    test_header_faults();
    test_crc_faults();
    test_length_faults();
    test_random_frames(250);

    @(negedge clk);
    frame_valid <= 1'b0;
    while (echoes_and_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes in %0d frames, %0d command bytes echoed.",
             bytes_sent, frames_sent, echo_count);
    $display("Verdicts: reject %0d, text %0d, acc0 %0d, acc1 %0d.",
             verdict_tally[0], verdict_tally[1], verdict_tally[2], verdict_tally[3]);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
